@@ rtl/assert_macros.svh @@
// Assertion macros shared by the heater burn timer RTL.
// No dependencies; every macro takes its clock and synchronous reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/hbt_pkg.sv @@
// Package for the heater burn timer: field widths, codes, reset values and types.
// No dependencies; used by the channel interfaces and the top level.
package hbt_pkg;

   localparam int BAR_LEVELS     = 5;
   localparam int LEVEL_STEP_W   = 6;
   localparam int BURN_STEP_W    = 13;
   localparam int DEBOUNCE_W     = 4;
   localparam int SAMPLE_W       = 8;
   localparam int BURN_W         = 15;
   localparam int COOK_W         = 16;
   localparam int SPLASH_W       = 5;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int LIT_W          = $clog2(BAR_LEVELS + 1);
   localparam int THRESH_W       = LEVEL_STEP_W + LIT_W;
   localparam int PRODUCT_W      = BURN_STEP_W + LIT_W;

   typedef logic [1:0]                    mode_type;
   typedef logic [CSR_INDEX_W-1:0]        csr_index_type;
   typedef logic [BAR_LEVELS-1:0]         bar_type;
   typedef logic [BURN_W-1:0]             burn_type;
   typedef logic signed [COOK_W-1:0]      cook_type;
   typedef logic signed [SPLASH_W-1:0]    splash_type;
   typedef logic [DEBOUNCE_W-1:0]         press_type;

   // Event kinds.
   localparam mode_type MODE_FAST   = 2'd0;
   localparam mode_type MODE_SLOW   = 2'd1;
   localparam mode_type MODE_POT    = 2'd2;
   localparam mode_type MODE_UNUSED = 2'd3;

   // Register indexes.
   localparam csr_index_type REG_LEVEL_STEP     = 2'd0;
   localparam csr_index_type REG_BURN_STEP      = 2'd1;
   localparam csr_index_type REG_DEBOUNCE_COUNT = 2'd2;
   localparam csr_index_type REG_SPLASH_TICKS   = 2'd3;

   // Register reset values.
   localparam logic [LEVEL_STEP_W-1:0] LEVEL_STEP_RESET = 6'd40;
   localparam logic [BURN_STEP_W-1:0]  BURN_STEP_RESET  = 13'd3450;
   localparam press_type               DEBOUNCE_RESET   = 4'd3;
   localparam logic [3:0]              SPLASH_RESET     = 4'd6;

   localparam burn_type BURN_MAX = {BURN_W{1'b1}};

   // One result word as held in the output register.
   typedef struct packed {
      logic     relay_on;
      bar_type  bar_leds;
      cook_type cook_left;
      logic     show_splash;
      logic     showed_on;
      logic     showed_off;
      logic     refresh_time;
   } rsp_type;

endpackage

@@ rtl/hbt_req_if.sv @@
// Event channel of the heater burn timer: valid/ready plus one event word.
// Depends on hbt_pkg.
interface hbt_req_if import hbt_pkg::*; ();
   logic                valid;
   logic                ready;
   mode_type            mode;
   logic                switch_level;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, mode, switch_level, sample, input ready);
   modport sink   (input valid, mode, switch_level, sample, output ready);
endinterface

@@ rtl/hbt_rsp_if.sv @@
// Result channel of the heater burn timer: valid/ready plus one result word.
// Depends on hbt_pkg.
interface hbt_rsp_if import hbt_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     relay_on;
   bar_type  bar_leds;
   cook_type cook_left;
   logic     show_splash;
   logic     showed_on;
   logic     showed_off;
   logic     refresh_time;

   modport source (output valid, relay_on, bar_leds, cook_left, show_splash, showed_on,
                   showed_off, refresh_time, input ready);
   modport sink   (input valid, relay_on, bar_leds, cook_left, show_splash, showed_on,
                   showed_off, refresh_time, output ready);
endinterface

@@ rtl/hbt_csr_if.sv @@
// Register write channel of the heater burn timer: valid/ready, index and data.
// Depends on hbt_pkg.
interface hbt_csr_if import hbt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/heater_burn_timer_controller.sv @@
// Top level of the heater burn timer controller.
// Depends on hbt_pkg, the three channel interfaces and assert_macros.svh.
//
// Usage:
// Events arrive on req_bus: a fast tick, a slow tick or a pot sample. Each
// accepted event word produces exactly one result word on rsp_bus carrying
// the relay drive, the LED bar, the remaining cook count and event flags.
// Register writes arrive on csr_bus, which is always ready; they are meant
// to be issued only while no event is in flight.
// An accepted word is held in an input register until the output register
// can advance; the edge at which it advances updates all controller state
// and loads the output register with the result word. One event per cycle
// is sustained while rsp_bus does not stall: every event is handled in a
// single state update.
// When rsp_bus stalls, the output register holds its word and the input
// register can still take one more event; only then does req_bus.ready drop.
// Reset (synchronous, active high) restores the register defaults, clears
// the controller state, loads both splash countdowns with six and empties
// both pipeline registers.
module heater_burn_timer_controller import hbt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hbt_req_if.sink    req_bus,
   hbt_rsp_if.source  rsp_bus,
   hbt_csr_if.sink    csr_bus
);

`include "assert_macros.svh"

   // Configuration registers. The splash tick count has no register: the
   // countdowns always reset to the fixed default, so writes to it are taken
   // and have no effect.
   logic [LEVEL_STEP_W-1:0] level_step_ff;
   logic [BURN_STEP_W-1:0]  burn_step_ff;
   press_type               debounce_ff;

   // Input register.
   logic                in_valid_ff;
   mode_type            in_mode_ff;
   logic                in_switch_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;

   // Controller state.
   logic [SAMPLE_W-1:0] pot_ff,       pot_in;
   burn_type            burn_ff,      burn_in;
   bar_type             bar_ff,       bar_in;
   logic                running_ff,   running_in;
   logic                toggle_ff,    toggle_in;
   cook_type            cook_ff,      cook_in;
   press_type           press_ff,     press_in;
   logic                last_sw_ff,   last_sw_in;
   splash_type          splash1_ff,   splash1_in;
   splash_type          splash2_ff,   splash2_in;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic advance;

   // Bar evaluation from the stored pot value.
   bar_type                 bar_eval;
   logic [LIT_W-1:0]        lit;
   logic [PRODUCT_W-1:0]    burn_product;
   burn_type                burn_eval;

   // The output register moves on when it is empty or being read.
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   // Level k is lit when the pot value exceeds k steps. Thresholds grow with k,
   // so the highest lit level is also the count of lit levels.
   always_comb begin
      bar_eval = '0;
      lit      = '0;
      for (int k = 1; k <= BAR_LEVELS; k++) begin
         if (THRESH_W'(pot_ff) > THRESH_W'(k) * THRESH_W'(level_step_ff)) begin
            bar_eval[k-1] = 1'b1;
            lit           = LIT_W'(k);
         end
      end
      burn_product = PRODUCT_W'(lit) * PRODUCT_W'(burn_step_ff);
      if (burn_product > PRODUCT_W'(BURN_MAX)) begin
         burn_eval = BURN_MAX;
      end else begin
         burn_eval = burn_product[BURN_W-1:0];
      end
   end

   // Next state and result for the event in the input register.
   always_comb begin
      pot_in     = pot_ff;
      burn_in    = burn_ff;
      bar_in     = bar_ff;
      running_in = running_ff;
      toggle_in  = toggle_ff;
      cook_in    = cook_ff;
      press_in   = press_ff;
      last_sw_in = last_sw_ff;
      splash1_in = splash1_ff;
      splash2_in = splash2_ff;
      rsp_in     = '0;

      unique case (in_mode_ff)
         MODE_FAST: begin
            bar_in  = bar_eval;
            burn_in = burn_eval;
            // Count down a timed burn; seeing zero switches the relay off and
            // the count settles at minus one.
            if (running_ff && burn_eval != '0) begin
               if (cook_ff == '0) begin
                  running_in        = 1'b0;
                  rsp_in.showed_off = 1'b1;
               end
               if (!cook_ff[COOK_W-1]) begin
                  cook_in = cook_ff - cook_type'(1);
               end
            end
         end
         MODE_SLOW: begin
            rsp_in.refresh_time = running_ff && burn_ff != '0;
            // The second splash countdown runs only after the first has
            // passed zero; both stop at minus one.
            if (!splash1_ff[SPLASH_W-1]) begin
               splash1_in = splash1_ff - splash_type'(1);
            end else if (!splash2_ff[SPLASH_W-1]) begin
               splash2_in = splash2_ff - splash_type'(1);
            end
            if (splash1_in == '0) begin
               rsp_in.show_splash = 1'b1;
            end else if (splash2_in == '0) begin
               running_in        = 1'b0;
               rsp_in.showed_off = 1'b1;
            end
            // Debounce: consecutive pressed ticks, wrapping at the counter width.
            if (!in_switch_ff && !last_sw_ff) begin
               press_in = press_ff + press_type'(1);
               if (press_in == debounce_ff) begin
                  toggle_in  = !toggle_ff;
                  running_in = !toggle_ff;
                  if (!toggle_ff) begin
                     rsp_in.showed_on = 1'b1;
                  end else begin
                     rsp_in.showed_off = 1'b1;
                  end
                  if (burn_ff != '0) begin
                     cook_in = !toggle_ff ? cook_type'({1'b0, burn_ff}) : '0;
                  end
                  press_in = '0;
               end
            end else begin
               press_in = '0;
            end
            last_sw_in = in_switch_ff;
         end
         MODE_POT: begin
            // The pot setting is frozen while the heater runs.
            if (!running_ff) begin
               pot_in = in_sample_ff;
            end
         end
         MODE_UNUSED: begin
         end
         default: begin
         end
      endcase

      rsp_in.relay_on  = running_in;
      rsp_in.bar_leds  = bar_in;
      rsp_in.cook_left = cook_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_step_ff <= LEVEL_STEP_RESET;
         burn_step_ff  <= BURN_STEP_RESET;
         debounce_ff   <= DEBOUNCE_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_LEVEL_STEP:     level_step_ff <= csr_bus.data[LEVEL_STEP_W-1:0];
            REG_BURN_STEP:      burn_step_ff  <= csr_bus.data[BURN_STEP_W-1:0];
            REG_DEBOUNCE_COUNT: debounce_ff   <= csr_bus.data[DEBOUNCE_W-1:0];
            REG_SPLASH_TICKS: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_mode_ff   <= req_bus.mode;
         in_switch_ff <= req_bus.switch_level;
         in_sample_ff <= req_bus.sample;
      end
   end

   // State update and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pot_ff       <= '0;
         burn_ff      <= '0;
         bar_ff       <= '0;
         running_ff   <= 1'b0;
         toggle_ff    <= 1'b0;
         cook_ff      <= '0;
         press_ff     <= '0;
         last_sw_ff   <= 1'b0;
         splash1_ff   <= splash_type'({1'b0, SPLASH_RESET});
         splash2_ff   <= splash_type'({1'b0, SPLASH_RESET});
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            pot_ff     <= pot_in;
            burn_ff    <= burn_in;
            bar_ff     <= bar_in;
            running_ff <= running_in;
            toggle_ff  <= toggle_in;
            cook_ff    <= cook_in;
            press_ff   <= press_in;
            last_sw_ff <= last_sw_in;
            splash1_ff <= splash1_in;
            splash2_ff <= splash2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.relay_on     = rsp_ff.relay_on;
   assign rsp_bus.bar_leds     = rsp_ff.bar_leds;
   assign rsp_bus.cook_left    = rsp_ff.cook_left;
   assign rsp_bus.show_splash  = rsp_ff.show_splash;
   assign rsp_bus.showed_on    = rsp_ff.showed_on;
   assign rsp_bus.showed_off   = rsp_ff.showed_off;
   assign rsp_bus.refresh_time = rsp_ff.refresh_time;

   // The heater only runs with the toggle set; timeouts clear just the relay.
   `ASSERT_IMPLIES(a_running_needs_toggle, clock, reset, running_ff, toggle_ff)
   // The cook count never passes below minus one.
   `ASSERT_IMPLIES(a_cook_floor, clock, reset, 1'b1, cook_ff >= -16'sd1)
   // A switch-on event always leaves the relay driven.
   `ASSERT_IMPLIES(a_on_drives_relay, clock, reset, rsp_valid_ff && rsp_ff.showed_on, rsp_ff.relay_on)
   // A held event in the input register is not dropped while the output stalls.
   `ASSERT_NEXT(a_hold_input, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule
